// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the sphere merger
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset
`define BSM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sphere merger assertion failed");
// Check an implication from one cycle to the next outside reset
`define BSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sphere merger sequence check failed");
`endif

// File: rtl/bsm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and command structs of the sphere merger
package bsm_pkg;
	localparam int CW     = 32;  // centre coordinate width
	localparam int RW     = 31;  // radius width
	localparam int DW     = 33;  // per-axis difference width
	localparam int AW     = 32;  // absolute difference width
	localparam int SW     = 66;  // squared distance width
	localparam int RTW    = 33;  // distance width
	localparam int SRW    = 36;  // root remainder width
	localparam int QRW    = 35;  // fraction remainder width
	localparam int QW     = 32;  // movement fraction width
	localparam int PW     = 64;  // product width
	localparam int AXES   = 3;
	localparam int CNTW   = 6;
	localparam int SQRT_STEPS = SW / 2;
	localparam int DIV_STEPS  = QW;
	localparam int MUL_STEPS  = AXES + 1;
	localparam logic [RW-1:0] RMAX = {RW{1'b1}};

	typedef enum logic [2:0] {
		KIND_FIRST = 3'd0,
		KIND_KEPT  = 3'd1,
		KIND_REPL  = 3'd2,
		KIND_CONC  = 3'd3,
		KIND_GROWN = 3'd4
	} kind_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CHK  = 8'b0000_0010,
		ST_SQ   = 8'b0000_0100,
		ST_SQRT = 8'b0000_1000,
		ST_DEC  = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_MOVE = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic       load;
		logic       sq_step;
		logic       sqrt_step;
		logic       decide;
		logic       div_step;
		logic       mv_step;
		logic [1:0] idx;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic grow;
	} sts_t;
endpackage

// File: rtl/bsm_if.sv
`timescale 1ns / 1ps
// Handshake channels carrying input spheres and merged results
interface bsm_in_if;
	logic                valid;
	logic                ready;
	logic                start_new;
	logic signed [31:0]  in_center_x;
	logic signed [31:0]  in_center_y;
	logic signed [31:0]  in_center_z;
	logic [30:0]         in_radius;
	modport source (output valid, start_new, in_center_x, in_center_y, in_center_z,
		in_radius, input ready);
	modport sink (input valid, start_new, in_center_x, in_center_y, in_center_z,
		in_radius, output ready);
endinterface

interface bsm_out_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  out_center_x;
	logic signed [31:0]  out_center_y;
	logic signed [31:0]  out_center_z;
	logic [30:0]         out_radius;
	logic [2:0]          merge_case;
	modport source (output valid, out_center_x, out_center_y, out_center_z, out_radius,
		merge_case, input ready);
	modport sink (input valid, out_center_x, out_center_y, out_center_z, out_radius,
		merge_case, output ready);
endinterface

// File: rtl/bsm_datapath.sv
`timescale 1ns / 1ps
// Datapath: running sphere, shared multiplier, square root and fraction units
module bsm_datapath
	import bsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  start_new,
	input  logic signed [CW-1:0]  in_center_x,
	input  logic signed [CW-1:0]  in_center_y,
	input  logic signed [CW-1:0]  in_center_z,
	input  logic [RW-1:0]         in_radius,
	output logic signed [CW-1:0]  out_center_x,
	output logic signed [CW-1:0]  out_center_y,
	output logic signed [CW-1:0]  out_center_z,
	output logic [RW-1:0]         out_radius,
	output logic [2:0]            merge_case
);
	logic signed [CW-1:0]  acc_c_q [AXES];
	logic [RW-1:0]         acc_r_q;
	logic                  acc_v_q;
	logic signed [DW-1:0]  dlt_q [AXES];
	logic [RW-1:0]         ir_q;
	logic signed [CW-1:0]  ic_q [AXES];
	logic                  first_q;
	kind_t                 kind_q;
	logic [SW-1:0]         rad_q;
	logic [RTW-1:0]        root_q;
	logic [SRW-1:0]        srem_q;
	logic [QRW-1:0]        drem_q;
	logic [QW-1:0]         m_q;
	logic [PW-1:0]         prod_q;
	logic signed [CW-1:0]  oc_q [AXES];
	logic [RW-1:0]         or_q;
	kind_t                 ok_q;

	logic signed [CW-1:0]  inc [AXES];
	logic [AW-1:0]         absd [AXES];
	logic [AW-1:0]         mul_a;
	logic [AW-1:0]         mul_b;
	logic [1:0]            prv;
	logic [SRW-1:0]        rem_sh;
	logic [SRW-1:0]        trial;
	logic [RTW:0]          d_ir;
	logic [RTW:0]          d_ar;
	logic [RTW+1:0]        nr;
	logic                  kept_c, repl_c, conc_c, grow_c;
	logic [QRW-1:0]        dt;
	logic [QRW-1:0]        den;
	logic [AW-1:0]         off;
	logic signed [CW+1:0]  mv;
	logic signed [CW-1:0]  mv_sat;

	assign inc[0] = in_center_x;
	assign inc[1] = in_center_y;
	assign inc[2] = in_center_z;

	// Take magnitudes of the axis differences
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			absd[i] = dlt_q[i][DW-1] ? AW'(-dlt_q[i]) : AW'(dlt_q[i]);
		end
	end

	// Select multiplier operands: squares, or magnitude times fraction
	always_comb begin
		case (cmd.idx)
			2'd0:    mul_a = absd[0];
			2'd1:    mul_a = absd[1];
			default: mul_a = absd[2];
		endcase
		mul_b = cmd.sq_step ? mul_a : m_q;
		prv   = cmd.idx - 2'd1;
	end

	// Square root step: bring down two bits, try to subtract
	assign rem_sh = {srem_q[SRW-3:0], rad_q[SW-1 -: 2]};
	assign trial  = SRW'({root_q, 2'b01});

	// Classify the merge from the distance
	always_comb begin
		d_ir   = {1'b0, root_q} + (RTW+1)'(ir_q);
		d_ar   = {1'b0, root_q} + (RTW+1)'(acc_r_q);
		nr     = (RTW+2)'(acc_r_q) + (RTW+2)'(root_q) + (RTW+2)'(ir_q);
		kept_c = d_ir <= (RTW+1)'(acc_r_q);
		repl_c = !kept_c && (d_ar <= (RTW+1)'(ir_q));
		conc_c = !kept_c && !repl_c && (root_q == '0);
		grow_c = !kept_c && !repl_c && !conc_c;
	end

	// Fraction step and centre move
	assign den = QRW'({root_q, 1'b0});
	assign dt  = {drem_q[QRW-2:0], 1'b0};
	assign off = prod_q[PW-1 -: AW];
	always_comb begin
		case (prv)
			2'd0:    mv = (CW+2)'(acc_c_q[0]);
			2'd1:    mv = (CW+2)'(acc_c_q[1]);
			default: mv = (CW+2)'(acc_c_q[2]);
		endcase
		case (prv)
			2'd0:    mv = dlt_q[0][DW-1] ? mv - $signed({2'b0, off}) : mv + $signed({2'b0, off});
			2'd1:    mv = dlt_q[1][DW-1] ? mv - $signed({2'b0, off}) : mv + $signed({2'b0, off});
			default: mv = dlt_q[2][DW-1] ? mv - $signed({2'b0, off}) : mv + $signed({2'b0, off});
		endcase
		if (mv > (CW+2)'(signed'({1'b0, {(CW-1){1'b1}}})))
			mv_sat = {1'b0, {(CW-1){1'b1}}};
		else if (mv < (CW+2)'(signed'({1'b1, {(CW-1){1'b0}}})))
			mv_sat = {1'b1, {(CW-1){1'b0}}};
		else
			mv_sat = CW'(mv);
	end

	assign sts.first = first_q;
	assign sts.grow  = grow_c;

	// Hold the running sphere
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_v_q <= 1'b0;
			acc_r_q <= '0;
			for (int i = 0; i < AXES; i++) acc_c_q[i] <= '0;
		end else if (cmd.load) begin
			if (start_new || !acc_v_q) begin
				acc_v_q <= 1'b1;
				acc_r_q <= in_radius;
				for (int i = 0; i < AXES; i++) acc_c_q[i] <= inc[i];
			end
		end else if (cmd.decide) begin
			if (repl_c) begin
				acc_r_q <= ir_q;
				for (int i = 0; i < AXES; i++) acc_c_q[i] <= ic_q[i];
			end else if (conc_c) begin
				acc_r_q <= (ir_q > acc_r_q) ? ir_q : acc_r_q;
			end else if (grow_c) begin
				acc_r_q <= (nr[RTW+1:1] > (RTW+1)'(RMAX)) ? RMAX : RW'(nr[RTW+1:1]);
			end
		end else if (cmd.mv_step && cmd.idx != 2'd0) begin
			case (prv)
				2'd0:    acc_c_q[0] <= mv_sat;
				2'd1:    acc_c_q[1] <= mv_sat;
				default: acc_c_q[2] <= mv_sat;
			endcase
		end
	end

	// Latch the item and run the arithmetic steps
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ir_q    <= in_radius;
			first_q <= start_new || !acc_v_q;
			kind_q  <= KIND_FIRST;
			rad_q   <= '0;
			root_q  <= '0;
			srem_q  <= '0;
			for (int i = 0; i < AXES; i++) begin
				ic_q[i]  <= inc[i];
				dlt_q[i] <= DW'(inc[i]) - DW'(acc_c_q[i]);
			end
		end
		if ((cmd.sq_step || cmd.mv_step) && cmd.idx != 2'd3)
			prod_q <= PW'(mul_a) * PW'(mul_b);
		if (cmd.sq_step && cmd.idx != 2'd0)
			rad_q <= rad_q + SW'(prod_q);
		if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				srem_q <= rem_sh - trial;
				root_q <= {root_q[RTW-2:0], 1'b1};
			end else begin
				srem_q <= rem_sh;
				root_q <= {root_q[RTW-2:0], 1'b0};
			end
		end
		if (cmd.decide) begin
			m_q    <= '0;
			drem_q <= QRW'(d_ir) - QRW'(acc_r_q);
			if (kept_c)      kind_q <= KIND_KEPT;
			else if (repl_c) kind_q <= KIND_REPL;
			else if (conc_c) kind_q <= KIND_CONC;
			else             kind_q <= KIND_GROWN;
		end
		if (cmd.div_step) begin
			if (dt >= den) begin
				drem_q <= dt - den;
				m_q    <= {m_q[QW-2:0], 1'b1};
			end else begin
				drem_q <= dt;
				m_q    <= {m_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			or_q <= acc_r_q;
			ok_q <= kind_q;
			for (int i = 0; i < AXES; i++) oc_q[i] <= acc_c_q[i];
		end
	end

	assign out_center_x = oc_q[0];
	assign out_center_y = oc_q[1];
	assign out_center_z = oc_q[2];
	assign out_radius   = or_q;
	assign merge_case   = ok_q;
endmodule

// File: rtl/bsm_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, squares, root, decision, fraction, move and hand-off
module bsm_ctrl
	import bsm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t            state_q, state_d;
	logic [CNTW-1:0]   cnt_q, cnt_d;
	logic              out_v_q;
	logic              last;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_v_q;

	// Decode state into datapath commands
	always_comb begin
		cmd           = '0;
		cmd.idx       = cnt_q[1:0];
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.sq_step   = (state_q == ST_SQ);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.decide    = (state_q == ST_DEC);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.mv_step   = (state_q == ST_MOVE);
		cmd.commit    = (state_q == ST_FIN) && (!out_v_q || out_ready);
	end

	// Advance the sequence
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + CNTW'(1);
		last    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (in_valid) state_d = ST_CHK;
			end
			ST_CHK: begin
				cnt_d   = '0;
				state_d = sts.first ? ST_FIN : ST_SQ;
			end
			ST_SQ: begin
				last = cnt_q == CNTW'(MUL_STEPS - 1);
				if (last) begin
					state_d = ST_SQRT;
					cnt_d   = '0;
				end
			end
			ST_SQRT: begin
				last = cnt_q == CNTW'(SQRT_STEPS - 1);
				if (last) begin
					state_d = ST_DEC;
					cnt_d   = '0;
				end
			end
			ST_DEC: begin
				cnt_d   = '0;
				state_d = sts.grow ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				last = cnt_q == CNTW'(DIV_STEPS - 1);
				if (last) begin
					state_d = ST_MOVE;
					cnt_d   = '0;
				end
			end
			ST_MOVE: begin
				last = cnt_q == CNTW'(MUL_STEPS - 1);
				if (last) begin
					state_d = ST_FIN;
					cnt_d   = '0;
				end
			end
			ST_FIN: begin
				cnt_d = '0;
				if (!out_v_q || out_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end
endmodule

// File: rtl/bounding_sphere_merger.sv
`timescale 1ns / 1ps
// Top level of the incremental bounding sphere merger
// A first sphere is passed straight on; the others run the squares, the root and the decision,
// and grown merges also the fraction and the centre move. A new item is taken only when idle;
// the 33-step root, the 32-step fraction unit and the shared 32x32 multiplier set the pace.
// A finished item waits in the output register while the next one is taken.
// Reset clears the running sphere, the sequencer and the output valid flag.
module bounding_sphere_merger
	import bsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	bsm_in_if.sink   sph_in,
	bsm_out_if.source sph_out
);
	cmd_t cmd;
	sts_t sts;

	bsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sph_in.valid),
		.in_ready  (sph_in.ready),
		.out_valid (sph_out.valid),
		.out_ready (sph_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.start_new    (sph_in.start_new),
		.in_center_x  (sph_in.in_center_x),
		.in_center_y  (sph_in.in_center_y),
		.in_center_z  (sph_in.in_center_z),
		.in_radius    (sph_in.in_radius),
		.out_center_x (sph_out.out_center_x),
		.out_center_y (sph_out.out_center_y),
		.out_center_z (sph_out.out_center_z),
		.out_radius   (sph_out.out_radius),
		.merge_case   (sph_out.merge_case)
	);
endmodule

// File: rtl/bsm_checker.sv
`timescale 1ns / 1ps
// Port checker of the sphere merger and its bind to the top level
`include "assert_macros.svh"
module bsm_checker
	import bsm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] merge_case
);
	logic acc;
	assign acc = in_valid && in_ready;

	`BSM_ASSERT_NEXT(a_busy_after_take, clk, arst_n, acc, !in_ready)
	`BSM_ASSERT_NEXT(a_no_instant_result, clk, arst_n, acc, !$rose(out_valid))
	`BSM_ASSERT(a_case_range, clk, arst_n, !out_valid || merge_case <= KIND_GROWN)
	`BSM_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(merge_case))
endmodule

bind bounding_sphere_merger bsm_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sph_in.valid),
	.in_ready   (sph_in.ready),
	.out_valid  (sph_out.valid),
	.out_ready  (sph_out.ready),
	.merge_case (sph_out.merge_case)
);

// File: tb/bsm_tb_if.sv
`timescale 1ns / 1ps
// Testbench folder holds no interfaces of its own: the handshake channels come from rtl/bsm_if.sv

// File: tb/bounding_sphere_merger_tb.sv
`timescale 1ns / 1ps
// Self-checking bench: merges random and directed spheres, compares each merged sphere
module bounding_sphere_merger_tb;
	import bsm_pkg::*;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]        rad;
		kind_t              kind;
	} sphere_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bsm_in_if  sph_in();
	bsm_out_if sph_out();

	// running sphere of the predictor
	logic signed [31:0] run_cx, run_cy, run_cz;
	logic [30:0]        run_rad;
	logic               run_valid;
	sphere_t            merged_q[$];
	int                 errors = 0;
	bit                 sink_idle_en = 1'b1;
	bit                 src_idle_en = 1'b1;
	bit                 hold_off = 1'b0;

	bounding_sphere_merger u_dut (.clk(clk), .arst_n(arst_n), .sph_in(sph_in),
		.sph_out(sph_out));

	always #1 clk = ~clk;

	// exact floor square root of a 66-bit sum of squares
	function automatic logic [32:0] isqrt(input logic [65:0] n);
		logic [34:0]  root;
		logic [34:0]  trial;
		logic [69:0]  prod;
		root = '0;
		for (int b = 34; b >= 0; b--) begin
			trial = root | (35'd1 << b);
			prod = trial * trial;
			if (prod <= {4'd0, n})
				root = trial;
		end
		return root[32:0];
	endfunction

	// move one axis by the fraction, rounding toward zero, then saturate
	function automatic logic signed [31:0] shift_axis(input logic signed [31:0] acc,
			input logic signed [32:0] dlt, input logic [31:0] frac);
		logic [32:0]        mag;
		logic [64:0]        prod;
		logic signed [34:0] res;
		mag = dlt < 0 ? -dlt : dlt;
		prod = mag * frac;
		res = dlt < 0 ? acc - $signed({2'b0, prod[64:32]}) : acc + $signed({2'b0, prod[64:32]});
		if (res > 35'sd2147483647)
			return 32'h7fffffff;
		if (res < -35'sd2147483648)
			return 32'h80000000;
		return res[31:0];
	endfunction

	// merge one sphere into the running sphere and return the report
	function automatic sphere_t merge_sphere(input logic sn, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z, input logic [30:0] r2);
		sphere_t            res;
		logic signed [32:0] dx, dy, dz;
		logic [65:0]        sumsq;
		logic [32:0]        span;
		logic [34:0]        sum_in, sum_run, grown;
		logic [34:0]        rem, den;
		logic [31:0]        frac;
		kind_t              k;
		if (sn)
			run_valid = 1'b0;
		if (!run_valid) begin
			run_cx = x; run_cy = y; run_cz = z; run_rad = r2;
			run_valid = 1'b1;
			k = KIND_FIRST;
		end else begin
			dx = x - run_cx; dy = y - run_cy; dz = z - run_cz;
			sumsq = 66'(66'(dx) * 66'(dx)) + 66'(66'(dy) * 66'(dy))
				+ 66'(66'(dz) * 66'(dz));
			span = isqrt(sumsq);
			sum_in = span + r2;
			sum_run = span + run_rad;
			if (sum_in <= run_rad) begin
				k = KIND_KEPT;
			end else if (sum_run <= r2) begin
				run_cx = x; run_cy = y; run_cz = z; run_rad = r2;
				k = KIND_REPL;
			end else if (span == 0) begin
				run_rad = run_rad > r2 ? run_rad : r2;
				k = KIND_CONC;
			end else begin
				grown = (run_rad + span + r2) >> 1;
				den = span << 1;
				rem = sum_in - run_rad;
				frac = '0;
				for (int i = 0; i < 32; i++) begin
					rem = rem << 1;
					frac = frac << 1;
					if (rem >= den) begin
						rem = rem - den;
						frac[0] = 1'b1;
					end
				end
				run_cx = shift_axis(run_cx, dx, frac);
				run_cy = shift_axis(run_cy, dy, frac);
				run_cz = shift_axis(run_cz, dz, frac);
				run_rad = grown > RMAX ? RMAX : grown[30:0];
				k = KIND_GROWN;
			end
		end
		res.cx = run_cx; res.cy = run_cy; res.cz = run_cz; res.rad = run_rad; res.kind = k;
		return res;
	endfunction

	// offer one sphere, with a random idle burst first, and hold until taken
	task automatic send_sphere(input logic sn, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z, input logic [30:0] r2);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			sph_in.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		sph_in.valid <= 1'b1;
		sph_in.start_new <= sn;
		sph_in.in_center_x <= x;
		sph_in.in_center_y <= y;
		sph_in.in_center_z <= z;
		sph_in.in_radius <= r2;
		merged_q.insert(merged_q.size(), merge_sphere(sn, x, y, z, r2));
		do @(posedge clk); while (!sph_in.ready);
	endtask

	task automatic release_input();
		sph_in.valid <= 1'b0;
	endtask

	// receiver readiness: random stall bursts, or a long hold-off on request
	initial begin
		sph_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				sph_out.ready <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				sph_out.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				sph_out.ready <= 1'b1;
			end else begin
				sph_out.ready <= 1'b1;
			end
		end
	end

	// compare each merged sphere with the oldest prediction
	always @(posedge clk) begin
		sphere_t want;
		if (arst_n && sph_out.valid && sph_out.ready) begin
			if (merged_q.size() == 0) begin
				$display("%0t: result with nothing pending, got %h %h %h %h %0d", $time,
					sph_out.out_center_x, sph_out.out_center_y, sph_out.out_center_z,
					sph_out.out_radius, sph_out.merge_case);
				errors++;
			end else begin
				want = merged_q.pop_front();
				if (sph_out.out_center_x !== want.cx) begin
					$display("%0t: centre x expected %h actual %h", $time, want.cx,
						sph_out.out_center_x);
					errors++;
				end
				if (sph_out.out_center_y !== want.cy) begin
					$display("%0t: centre y expected %h actual %h", $time, want.cy,
						sph_out.out_center_y);
					errors++;
				end
				if (sph_out.out_center_z !== want.cz) begin
					$display("%0t: centre z expected %h actual %h", $time, want.cz,
						sph_out.out_center_z);
					errors++;
				end
				if (sph_out.out_radius !== want.rad) begin
					$display("%0t: radius expected %h actual %h", $time, want.rad,
						sph_out.out_radius);
					errors++;
				end
				if (sph_out.merge_case !== want.kind) begin
					$display("%0t: merge case expected %0d actual %0d", $time, want.kind,
						sph_out.merge_case);
					errors++;
				end
			end
		end
	end

	// extremes, the first, kept, replaced and grown merge cases and radius saturation
	task automatic test_directed();
		send_sphere(1'b1, 32'sh0, 32'sh0, 32'sh0, 31'h10000);
		send_sphere(1'b0, 32'sh100, 32'sh0, 32'sh0, 31'h100);
		send_sphere(1'b0, 32'sh0, 32'sh0, 32'sh0, 31'h40000);
		send_sphere(1'b0, 32'sh0, 32'sh0, 32'sh0, 31'h40000);
		send_sphere(1'b0, 32'sh80000, 32'sh0, 32'sh0, 31'h40000);
		send_sphere(1'b0, -32'sh90000, 32'sh30000, -32'sh10000, 31'h8000);
		send_sphere(1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
		send_sphere(1'b0, -32'sh80000000, -32'sh80000000, -32'sh80000000, 31'h7fffffff);
		send_sphere(1'b0, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, 31'h0);
		send_sphere(1'b1, -32'sh80000000, 32'sh7fffffff, 32'sh0, 31'h0);
		send_sphere(1'b0, 32'sh7fffffff, -32'sh80000000, -32'sh80000000, 31'h0);
		send_sphere(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
		send_sphere(1'b1, 32'sh0, 32'sh0, 32'sh0, 31'h0);
		send_sphere(1'b0, 32'sh0, 32'sh0, 32'sh0, 31'h0);
		send_sphere(1'b0, 32'sh1, 32'sh0, 32'sh0, 31'h0);
		send_sphere(1'b0, 32'sh55555555, -32'sh2aaaaaab, 32'sh2aaaaaaa, 31'h2aaaaaaa);
		release_input();
	endtask

	// random clusters: small local spheres mostly, with wide-range noise
	task automatic test_random(input int count);
		logic signed [31:0] bx, by, bz;
		logic [31:0]        spread;
		int                 sel;
		bx = $urandom; by = $urandom; bz = $urandom;
		spread = 32'h0004_0000;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				bx = $signed($urandom) >>> $urandom_range(0, 12);
				by = $signed($urandom) >>> $urandom_range(0, 12);
				bz = $signed($urandom) >>> $urandom_range(0, 12);
				spread = 32'h1 << $urandom_range(4, 30);
				send_sphere(1'b1, bx, by, bz, 31'($urandom & spread));
			end else if (sel == 1) begin
				send_sphere(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
					31'($urandom));
			end else begin
				send_sphere(1'b0, bx + $signed($urandom_range(0, spread) - (spread >> 1)),
					by + $signed($urandom_range(0, spread) - (spread >> 1)),
					bz + $signed($urandom_range(0, spread) - (spread >> 1)),
					31'($urandom_range(0, spread >> $urandom_range(0, 3))));
			end
		end
		release_input();
	endtask

	// stall the receiver long enough to back the block up into its input
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			test_random(6);
			begin
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		wait (merged_q.size() == 0);
	endtask

	task automatic test_no_idle();
		sink_idle_en = 1'b0;
		src_idle_en = 1'b0;
		test_random(120);
	endtask

	initial begin
		sph_in.valid = 1'b0;
		sph_in.start_new = 1'b0;
		sph_in.in_center_x = '0;
		sph_in.in_center_y = '0;
		sph_in.in_center_z = '0;
		sph_in.in_radius = '0;
		run_valid = 1'b0;
		run_cx = '0; run_cy = '0; run_cz = '0; run_rad = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(340);
		test_backpressure();
		test_random(340);
		test_no_idle();
		wait (merged_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// overall run limit
	initial begin
		#1500000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
